// ----- src/tse_pkg.sv -----
// ----------------------------------------------------------------------------
// tse_pkg: shared types and constants of the server-name extractor
// Parse phases, parser state, status codes and the result format used by the
// parse step, the result queue and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package tse_pkg;

   localparam int LEN_W     = 16;  // payload length as compared by the parser
   localparam int IDX_W     = 16;  // byte position counter
   localparam int POS_W     = 18;  // parse positions and extensions end
   localparam int SUM_W     = 19;  // position arithmetic with headroom
   localparam int HIST_TAPS = 8;   // current byte plus seven earlier ones
   localparam int TAP_IDX_W = 3;
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = 2;
   localparam int RSP_CNT_W = 3;

   localparam logic [7:0]  SID_LEN_POS      = 8'd43;
   localparam logic [7:0]  MIN_LENGTH       = 8'd43;
   localparam logic [7:0]  HELLO_TYPE_POS   = 8'd5;
   localparam logic [7:0]  REC_HANDSHAKE    = 8'h16;
   localparam logic [7:0]  MSG_CLIENT_HELLO = 8'h01;
   localparam logic [15:0] EXT_SERVER_NAME  = 16'h0000;
   localparam logic [7:0]  HOST_NAME_TYPE   = 8'h00;

   typedef enum logic [2:0] {
      ST_FOUND         = 3'd0,
      ST_TOO_SHORT     = 3'd1,
      ST_NOT_HANDSHAKE = 3'd2,
      ST_NOT_HELLO     = 3'd3,
      ST_TRUNCATED     = 3'd4,
      ST_NO_NAME       = 3'd5
   } status_type;

   typedef enum logic [15:0] {
      PH_HDR     = 16'h0001,
      PH_SID     = 16'h0002,
      PH_CIPH_HI = 16'h0004,
      PH_CIPH_LO = 16'h0008,
      PH_COMP    = 16'h0010,
      PH_EXTL_HI = 16'h0020,
      PH_EXTL_LO = 16'h0040,
      PH_ET_HI   = 16'h0080,
      PH_ET_LO   = 16'h0100,
      PH_EL_HI   = 16'h0200,
      PH_EL_LO   = 16'h0400,
      PH_NT      = 16'h0800,
      PH_NL_HI   = 16'h1000,
      PH_NL_LO   = 16'h2000,
      PH_NAME    = 16'h4000,
      PH_DONE    = 16'h8000
   } phase_type;

   typedef struct packed {
      phase_type        phase;
      logic [POS_W-1:0] pos;
      logic [POS_W-1:0] ext_end;
      logic [7:0]       high;
      logic [15:0]      ext_code;
      logic [15:0]      ext_len;
      logic [15:0]      name_left;
      status_type       verdict;
   } parse_state_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
      logic       last;
   } name_out_type;

   typedef struct packed {
      logic       is_status;
      logic [7:0] name_byte;
      logic       name_end;
      logic [2:0] status;
      logic       run_last;
   } rsp_type;

   typedef struct packed {
      logic    first_valid;
      rsp_type first;
      logic    second_valid;
      rsp_type second;
   } rsp_pair_type;

   function automatic parse_state_type parse_reset_state();
      parse_state_type r;
      r.phase     = PH_HDR;
      r.pos       = '0;
      r.ext_end   = '0;
      r.high      = '0;
      r.ext_code  = '0;
      r.ext_len   = '0;
      r.name_left = '0;
      r.verdict   = ST_NO_NAME;
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- src/tls_sni_extractor_unit.sv -----
// ----------------------------------------------------------------------------
// tls_sni_extractor_unit: TLS ClientHello server-name extractor
// Parses a TCP payload byte by byte and streams out the server host name
// followed by an end-of-packet status.
// ----------------------------------------------------------------------------
// The unit takes one payload byte per cycle while req_ready is high. A byte's
// results enter the queue at the edge of its transfer and are offered on
// rsp_valid once the results before them are taken. The parser does one field
// advance per cycle on the current byte and the seven before it. Normally one
// advance covers a byte; when a rejected server-name extension is shorter
// than what was already read, the next extension header lies in bytes
// already received and the parser walks back through them one field per
// cycle, holding req_ready low on that byte. Results go through a four-entry
// queue: a byte gives at most two results (a name byte and the status on the
// last payload byte), and req_ready also drops while fewer than two entries
// are free, so with rsp_ready held high only the walk back stalls the input.
// The payload length is sampled on the first byte of a packet and masked to
// LENGTH_BITS bits; req_packet_end returns the parser to its reset state.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module tls_sni_extractor_unit import tse_pkg::*; #(
   parameter int LENGTH_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // payload byte channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_payload_byte,
   input  logic [15:0] req_total_length,
   input  logic        req_packet_end,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_is_status,
   output logic [7:0]  rsp_name_byte,
   output logic        rsp_name_end,
   output logic [2:0]  rsp_status,
   output logic        rsp_run_last
);

   // packet position and sampled length
   logic [IDX_W-1:0]           byte_index_ff, byte_index_in;
   logic [LENGTH_BITS-1:0]     length_held_ff, length_held_in;
   logic [LENGTH_BITS-1:0]     length_now;
   logic [LEN_W-1:0]           len_ext;

   // parser state and the last seven payload bytes
   parse_state_type             state_ff, state_in;
   logic [HIST_TAPS-2:0][7:0]   taps_ff, taps_in;
   logic [HIST_TAPS-1:0][7:0]   win;

   // one field advance per cycle
   parse_state_type             fin;
   name_out_type                emit;
   logic                        more;

   logic                        accept;
   status_type                  status_now;
   rsp_type                     name_rsp;
   rsp_type                     status_rsp;
   rsp_pair_type                push;
   rsp_type                     rsp_data;
   logic                        room;

   // the byte is taken only once the parse no longer needs it
   assign accept     = req_valid && req_ready;
   assign req_ready  = room && !more;

   // length is taken from the port on the first byte of a packet
   assign length_now = (byte_index_ff == '0) ? req_total_length[LENGTH_BITS-1:0]
                                             : length_held_ff;
   assign len_ext    = LEN_W'(length_now);

   // window: index 0 is the current byte, index k the byte k positions back
   assign win = {taps_ff, req_payload_byte};

   tse_step u_step (
      .cur      (state_ff),
      .emit_in  ('0),
      .idx      (byte_index_ff),
      .len      (len_ext),
      .win      (win),
      .nxt      (fin),
      .emit_out (emit)
   );

   // another field of the current byte or an earlier one still waits
   assign more = (fin.phase != PH_DONE) && (fin.pos <= POS_W'(byte_index_ff))
                 && !emit.valid;

   // an unfinished parse at packet end counts as truncated
   assign status_now = (fin.phase == PH_DONE) ? fin.verdict : ST_TRUNCATED;

   always_comb begin
      name_rsp.is_status  = 1'b0;
      name_rsp.name_byte  = emit.data;
      name_rsp.name_end   = emit.last;
      name_rsp.status     = ST_FOUND;
      name_rsp.run_last   = !req_packet_end;

      status_rsp.is_status = 1'b1;
      status_rsp.name_byte = '0;
      status_rsp.name_end  = 1'b0;
      status_rsp.status    = status_now;
      status_rsp.run_last  = 1'b1;

      // name byte goes first when both come from one byte
      push.first_valid  = accept && (emit.valid || req_packet_end);
      push.first        = emit.valid ? name_rsp : status_rsp;
      push.second_valid = accept && emit.valid && req_packet_end;
      push.second       = status_rsp;
   end

   always_comb begin
      byte_index_in  = byte_index_ff;
      length_held_in = length_held_ff;
      state_in       = state_ff;
      taps_in        = taps_ff;
      if (accept) begin
         if (req_packet_end) begin
            byte_index_in  = '0;
            length_held_in = '0;
            state_in       = parse_reset_state();
            taps_in        = '0;
         end else begin
            // position saturates on very long streams
            if (byte_index_ff != '1) begin
               byte_index_in = byte_index_ff + IDX_W'(1);
            end
            length_held_in = length_now;
            state_in       = fin;
            taps_in        = {taps_ff[HIST_TAPS-3:0], req_payload_byte};
         end
      end else if (req_valid && more) begin
         // walking back through earlier bytes, the byte itself stays waiting
         state_in = fin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff  <= '0;
         length_held_ff <= '0;
         state_ff       <= parse_reset_state();
         taps_ff        <= '0;
      end else begin
         byte_index_ff  <= byte_index_in;
         length_held_ff <= length_held_in;
         state_ff       <= state_in;
         taps_ff        <= taps_in;
      end
   end

   tse_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   assign rsp_is_status = rsp_data.is_status;
   assign rsp_name_byte = rsp_data.name_byte;
   assign rsp_name_end  = rsp_data.name_end;
   assign rsp_status    = rsp_data.status;
   assign rsp_run_last  = rsp_data.run_last;

`ifndef SYNTHESIS
   // a transfer leaves the parse waiting for a later byte, finished, or
   // stopped on a name byte
   a_parse_settled: assert property (@(posedge clock) disable iff (reset)
      accept |-> (fin.phase == PH_DONE || fin.pos > POS_W'(byte_index_ff) || emit.valid))
      else $error("byte taken before its parse settled");

   // name bytes only come out of the name phase
   a_name_phase: assert property (@(posedge clock) disable iff (reset)
      accept && emit.valid |-> state_ff.phase == PH_NAME)
      else $error("name byte outside name phase");

   // the final name byte ends the parse with a found verdict
   a_name_found: assert property (@(posedge clock) disable iff (reset)
      accept && emit.valid && emit.last && !req_packet_end |=>
         state_ff.phase == PH_DONE && state_ff.verdict == ST_FOUND)
      else $error("final name byte did not finish the parse");

   // packet end brings the parser back to the start of a packet
   a_packet_restart: assert property (@(posedge clock) disable iff (reset)
      accept && req_packet_end |=> byte_index_ff == '0 && state_ff.phase == PH_HDR)
      else $error("parser not restarted after packet end");
`endif

endmodule

`default_nettype wire

// ----- src/tse_step.sv -----
// ----------------------------------------------------------------------------
// tse_step: one parse advance
// Consumes the byte at the current parse position, taken from the history
// window, and moves the parser state forward by one field.
// ----------------------------------------------------------------------------
`default_nettype none

module tse_step import tse_pkg::*; (
   input  parse_state_type                 cur,
   input  name_out_type                    emit_in,
   input  logic [IDX_W-1:0]                idx,
   input  logic [LEN_W-1:0]                len,
   input  logic [HIST_TAPS-1:0][7:0]       win,
   output parse_state_type                 nxt,
   output name_out_type                    emit_out
);

   function automatic parse_state_type parse_finish(parse_state_type s, status_type code);
      parse_state_type r;
      r         = s;
      r.verdict = code;
      r.phase   = PH_DONE;
      return r;
   endfunction

   // next extension header, if it still fits before the extensions end
   function automatic parse_state_type begin_ext(parse_state_type s, logic [SUM_W-1:0] q);
      parse_state_type r;
      r = s;
      if (q + SUM_W'(4) <= SUM_W'(s.ext_end)) begin
         r.pos   = POS_W'(q);
         r.phase = PH_ET_HI;
      end else begin
         r.verdict = ST_NO_NAME;
         r.phase   = PH_DONE;
      end
      return r;
   endfunction

   logic [POS_W-1:0] idx_pos;
   logic [POS_W-1:0] back_ofs;
   logic             active;
   logic             stray;
   logic [7:0]       v;
   logic [15:0]      fld;
   logic [SUM_W-1:0] p;
   logic [SUM_W-1:0] p1;
   logic [SUM_W-1:0] len_s;
   logic [SUM_W-1:0] end_s;
   logic [SUM_W-1:0] w_byte;
   logic [SUM_W-1:0] w_fld;

   assign idx_pos  = POS_W'(idx);
   assign back_ofs = idx_pos - cur.pos;
   assign active   = (cur.phase != PH_DONE) && (cur.pos <= idx_pos) && !emit_in.valid;
   assign stray    = back_ofs > POS_W'(HIST_TAPS - 1);
   assign v        = win[back_ofs[TAP_IDX_W-1:0]];
   assign fld      = {cur.high, v};
   assign p        = SUM_W'(cur.pos);
   assign p1       = p + SUM_W'(1);
   assign len_s    = SUM_W'(len);
   assign end_s    = SUM_W'(cur.ext_end);
   assign w_byte   = p1 + SUM_W'(v);
   assign w_fld    = p1 + SUM_W'(fld);

   always_comb begin
      parse_state_type tmp;
      tmp      = cur;
      nxt      = cur;
      emit_out = emit_in;
      if (active) begin
         if (stray) begin
            nxt = parse_finish(cur, ST_TRUNCATED);
         end else begin
            case (cur.phase)
               PH_HDR: begin
                  if (cur.pos == '0) begin
                     if (len_s < SUM_W'(MIN_LENGTH)) begin
                        nxt = parse_finish(cur, ST_TOO_SHORT);
                     end else if (v != REC_HANDSHAKE) begin
                        nxt = parse_finish(cur, ST_NOT_HANDSHAKE);
                     end else begin
                        nxt.pos = POS_W'(HELLO_TYPE_POS);
                     end
                  end else begin
                     if (v != MSG_CLIENT_HELLO) begin
                        nxt = parse_finish(cur, ST_NOT_HELLO);
                     end else begin
                        tmp     = cur;
                        tmp.pos = POS_W'(SID_LEN_POS);
                        if (SUM_W'(SID_LEN_POS) >= len_s) begin
                           nxt = parse_finish(tmp, ST_TRUNCATED);
                        end else begin
                           nxt       = tmp;
                           nxt.phase = PH_SID;
                        end
                     end
                  end
               end
               PH_SID, PH_COMP: begin
                  if (w_byte + SUM_W'(2) >= len_s) begin
                     nxt = parse_finish(cur, ST_TRUNCATED);
                  end else begin
                     nxt.pos   = POS_W'(w_byte);
                     nxt.phase = (cur.phase == PH_SID) ? PH_CIPH_HI : PH_EXTL_HI;
                  end
               end
               PH_CIPH_HI, PH_EXTL_HI, PH_ET_HI, PH_EL_HI, PH_NL_HI: begin
                  nxt.high = v;
                  nxt.pos  = POS_W'(p1);
                  case (cur.phase)
                     PH_CIPH_HI: nxt.phase = PH_CIPH_LO;
                     PH_EXTL_HI: nxt.phase = PH_EXTL_LO;
                     PH_ET_HI:   nxt.phase = PH_ET_LO;
                     PH_EL_HI:   nxt.phase = PH_EL_LO;
                     default:    nxt.phase = PH_NL_LO;
                  endcase
               end
               PH_CIPH_LO: begin
                  if (w_fld >= len_s) begin
                     nxt = parse_finish(cur, ST_TRUNCATED);
                  end else begin
                     nxt.pos   = POS_W'(w_fld);
                     nxt.phase = PH_COMP;
                  end
               end
               PH_EXTL_LO: begin
                  // extensions end is clipped to the payload length
                  tmp         = cur;
                  tmp.ext_end = (w_fld > len_s) ? POS_W'(len_s) : POS_W'(w_fld);
                  nxt         = begin_ext(tmp, p1);
               end
               PH_ET_LO: begin
                  nxt.ext_code = fld;
                  nxt.pos      = POS_W'(p1);
                  nxt.phase    = PH_EL_HI;
               end
               PH_EL_LO: begin
                  tmp         = cur;
                  tmp.ext_len = fld;
                  if (cur.ext_code == EXT_SERVER_NAME) begin
                     if (p + SUM_W'(6) > end_s) begin
                        nxt = parse_finish(tmp, ST_TRUNCATED);
                     end else begin
                        nxt       = tmp;
                        nxt.pos   = POS_W'(p + SUM_W'(3));  // skip the list length
                        nxt.phase = PH_NT;
                     end
                  end else begin
                     nxt = begin_ext(tmp, w_fld);
                  end
               end
               PH_NT: begin
                  // name type parked in ext_code until the name length is in
                  nxt.ext_code = 16'(v);
                  nxt.pos      = POS_W'(p1);
                  nxt.phase    = PH_NL_HI;
               end
               PH_NL_LO: begin
                  tmp           = cur;
                  tmp.name_left = fld;
                  if (cur.ext_code == 16'(HOST_NAME_TYPE) && w_fld <= end_s) begin
                     if (fld == '0) begin
                        nxt = parse_finish(tmp, ST_NO_NAME);
                     end else begin
                        nxt       = tmp;
                        nxt.pos   = POS_W'(p1);
                        nxt.phase = PH_NAME;
                     end
                  end else begin
                     // rejected entry: skip the extension, possibly backward
                     nxt = begin_ext(tmp, p - SUM_W'(4) + SUM_W'(cur.ext_len));
                  end
               end
               PH_NAME: begin
                  emit_out.valid = 1'b1;
                  emit_out.data  = v;
                  emit_out.last  = (cur.name_left <= 16'd1);
                  if (cur.name_left <= 16'd1) begin
                     tmp           = cur;
                     tmp.name_left = '0;
                     nxt           = parse_finish(tmp, ST_FOUND);
                  end else begin
                     nxt.name_left = cur.name_left - 16'd1;
                     nxt.pos       = POS_W'(p1);
                  end
               end
               default: begin
                  nxt = parse_finish(cur, ST_TRUNCATED);
               end
            endcase
         end
      end
   end

endmodule

`default_nettype wire

// ----- src/tse_rsp_queue.sv -----
// ----------------------------------------------------------------------------
// tse_rsp_queue: result queue
// Small queue that takes up to two results per cycle and hands out one per
// transfer on the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module tse_rsp_queue import tse_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  rsp_pair_type push,
   output logic         room,
   output logic         out_valid,
   input  logic         out_ready,
   output rsp_type      out_data
);

   rsp_type                mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]   count_ff, count_in;
   logic                   pop;

   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   assign room      = (count_ff <= RSP_CNT_W'(RSP_DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push.first_valid) + RSP_PTR_W'(push.second_valid);
      rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(pop);
      count_in  = count_ff + RSP_CNT_W'(push.first_valid) + RSP_CNT_W'(push.second_valid)
                  - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.first_valid) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.second_valid) begin
         mem_ff[wr_ptr_ff + RSP_PTR_W'(1)] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire
